// ----- design/mbd_pkg.sv -----
// Shared types and constants for the multi-button debounce block.
// No dependencies; imported by every module of the block.
`default_nettype none
package mbd_pkg;

  localparam int NUM_BUTTONS = 12;
  localparam int TICK_W      = 32;
  localparam int DEBOUNCE_W  = 16;
  localparam int HELD_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RESET = DEBOUNCE_W'(20);
  localparam logic [NUM_BUTTONS-1:0] POLARITY_RESET = {NUM_BUTTONS{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 1'b1;

  // What one lane reports for the poll it just took
  typedef struct packed {
    logic held;
    logic fresh;
  } lane_flags_t;

endpackage
`default_nettype wire

// ----- design/mbd_lane.sv -----
// One button lane: idle / confirming / held machine with its press timestamp.
// Depends on mbd_pkg.
`default_nettype none
module mbd_lane (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             take,
  input  wire logic                             pressed,
  input  wire logic [mbd_pkg::TICK_W-1:0]       tick_now,
  input  wire logic [mbd_pkg::DEBOUNCE_W-1:0]   debounce_ticks,
  output mbd_pkg::lane_flags_t                  flags
);
  import mbd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2
  } phase_t;

  phase_t              phase;
  phase_t              phase_next;
  logic [TICK_W-1:0]   press_stamp;
  logic [TICK_W-1:0]   elapsed;
  logic                start_capture;

  // wraps modulo 2^32 by width
  assign elapsed = tick_now - press_stamp;

  always_comb begin
    phase_next    = phase;
    start_capture = 1'b0;
    flags.fresh   = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase_next    = PH_CONFIRM;
          start_capture = 1'b1;
        end
      end
      PH_CONFIRM: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end else if (elapsed >= TICK_W'(debounce_ticks)) begin
          phase_next  = PH_HELD;
          flags.fresh = 1'b1;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    flags.held = (phase_next == PH_HELD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && start_capture) begin
      press_stamp <= tick_now;
    end
  end

endmodule
`default_nettype wire

// ----- design/mbd_merge.sv -----
// Merge stage: gathers lane flags into the held word and new-press mask and
// holds them in the output register. Depends on mbd_pkg.
`default_nettype none
module mbd_merge (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              take,
  input  mbd_pkg::lane_flags_t                   lane_flags [mbd_pkg::NUM_BUTTONS],
  output logic                                   space,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mbd_pkg::HELD_W-1:0]             held_word,
  output logic [mbd_pkg::NUM_BUTTONS-1:0]        new_press_mask
);
  import mbd_pkg::*;

  localparam logic [HELD_W-1:0] LOW_MASK = HELD_W'((1 << (HELD_W - NUM_BUTTONS)) - 1);

  logic [NUM_BUTTONS-1:0] held_vec;
  logic [NUM_BUTTONS-1:0] held_vec_next;
  logic [NUM_BUTTONS-1:0] fresh_next;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      held_vec_next[i] = lane_flags[i].held;
      fresh_next[i]    = lane_flags[i].fresh;
    end
  end

  // button i lands in bit HELD_W-1-i; bits below the buttons stay zero
  always_comb begin
    held_word = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      held_word[HELD_W-1-i] = held_vec[i];
    end
  end

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_vec       <= held_vec_next;
      new_press_mask <= fresh_next;
    end
  end

  a_low_bits_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((held_word & LOW_MASK) == '0))
    else $error("held_word low bits set");

  a_fresh_is_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((new_press_mask & ~held_vec) == '0))
    else $error("new press reported for a button not held");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted poll did not produce a word");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !take)
    else $error("poll taken while output word stalled");

endmodule
`default_nettype wire

// ----- design/multi_button_debounce.sv -----
// Result word follows in the cycle after acceptance; one poll per cycle while not stalled.
// All button lanes update together on the accepted poll and the merge register holds the word.
// The result register decouples the sides: a poll is taken while the held word is being taken.
// Reset (synchronous, active high): every button idle and released, output empty,
// debounce_ticks = 20, active_high_mask = all ones.
// Depends on mbd_pkg, mbd_lane, mbd_merge.
`default_nettype none
module multi_button_debounce (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [mbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mbd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [mbd_pkg::TICK_W-1:0]        tick_now,
  input  wire logic [mbd_pkg::NUM_BUTTONS-1:0]   pin_levels,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [mbd_pkg::HELD_W-1:0]             held_word,
  output logic [mbd_pkg::NUM_BUTTONS-1:0]        new_press_mask
);
  import mbd_pkg::*;

  logic [DEBOUNCE_W-1:0]  debounce_ticks;
  logic [NUM_BUTTONS-1:0] active_high_mask;
  logic [NUM_BUTTONS-1:0] pressed;
  logic                   take;
  lane_flags_t            lane_flags [NUM_BUTTONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      active_high_mask <= POLARITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ticks   <= cfg_data[DEBOUNCE_W-1:0];
        REG_POLARITY: active_high_mask <= cfg_data[NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  assign take    = in_valid && in_ready;
  // pressed when the pin level matches the button's polarity
  assign pressed = ~(pin_levels ^ active_high_mask);

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    mbd_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .take           (take),
      .pressed        (pressed[i]),
      .tick_now       (tick_now),
      .debounce_ticks (debounce_ticks),
      .flags          (lane_flags[i])
    );
  end

  mbd_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .lane_flags     (lane_flags),
    .space          (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .held_word      (held_word),
    .new_press_mask (new_press_mask)
  );

endmodule
`default_nettype wire
